// ===== rtl/ecbdd_pkg.sv =====
// ----------------------------------------------------------------------------
// ecbdd_pkg
// Shared types and constants of the repeated-block detector.
// ----------------------------------------------------------------------------
package ecbdd_pkg;

    localparam int MAX_BLOCKS   = 64;
    localparam int BLOCK_CHARS  = 32;
    localparam int CHAR_W       = 8;
    localparam int WORD_W       = 64;
    localparam int WORDS_PER_BLK = BLOCK_CHARS * CHAR_W / WORD_W;
    localparam int CHARS_PER_WORD = WORD_W / CHAR_W;

    localparam int POS_W   = $clog2(BLOCK_CHARS);
    localparam int WSEL_W  = $clog2(WORDS_PER_BLK);
    localparam int BSEL_W  = $clog2(CHARS_PER_WORD);
    localparam int BLK_W   = $clog2(MAX_BLOCKS + 1);
    localparam int IDX_W   = $clog2(MAX_BLOCKS);
    localparam int ADDR_W  = IDX_W + WSEL_W;
    localparam int PTR_W   = ADDR_W + 1;
    localparam int MEM_DEPTH = MAX_BLOCKS * WORDS_PER_BLK;

    localparam int LINE_W  = 16;
    localparam int COUNT_W = 11;
    localparam int OUT_W   = 56;

    localparam logic [CHAR_W-1:0]  NEWLINE_CODE = CHAR_W'(10);
    localparam logic [COUNT_W-1:0] COUNT_MAX    = '1;
    localparam logic [LINE_W-1:0]  LINE_MAX     = '1;
    localparam logic [BLK_W-1:0]   BLK_LIMIT    = BLK_W'(MAX_BLOCKS);
    localparam logic [POS_W-1:0]   LAST_POS     = POS_W'(BLOCK_CHARS - 1);
    localparam logic [WSEL_W-1:0]  LAST_WORD    = WSEL_W'(WORDS_PER_BLK - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_WR
    } t_state;

    typedef struct packed {
        logic [COUNT_W-1:0] best_matches;
        logic [LINE_W-1:0]  best_line;
        logic [COUNT_W-1:0] line_matches;
        logic [LINE_W-1:0]  line_number;
    } t_result;

endpackage

// ===== rtl/ecb_duplicate_block_detector_top.sv =====
// The result of a newline is registered and appears in the cycle after its transaction.
// Throughput: one character per cycle, except one that completes a block within capacity:
// it holds tready low while the block is compared with the blocks stored in the line,
// one stored word per cycle through the single RAM port, and then while its four words
// are written to the store. A stalled result also holds tready low.
// Reset: synchronous active low clears control and counters, not the block store.
// ----------------------------------------------------------------------------
// ecb_duplicate_block_detector_top
// Counts equal 32-character block pairs per text line and tracks the best line.
// ----------------------------------------------------------------------------
module ecb_duplicate_block_detector_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [ecbdd_pkg::CHAR_W-1:0]  i_s_axis_tdata,  // [7:0] char_code
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // [15:0] line_number, [26:16] line_matches, [42:27] best_line,
    // [53:43] best_matches, [55:54] zero
    output logic [ecbdd_pkg::OUT_W-1:0]   o_m_axis_tdata
);

    import ecbdd_pkg::*;

    t_state r_state, n_state;

    logic [BLOCK_CHARS-1:0][CHAR_W-1:0] r_asm, n_asm;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic [BLK_W-1:0]   r_blocks, n_blocks;
    logic [COUNT_W-1:0] r_match, n_match;
    logic [LINE_W-1:0]  r_lines, n_lines;
    logic [LINE_W-1:0]  r_best_line, n_best_line;
    logic [COUNT_W-1:0] r_best_cnt, n_best_cnt;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic               r_cmp_vld, n_cmp_vld;
    logic [WSEL_W-1:0]  r_cmp_word, n_cmp_word;
    logic               r_eq, n_eq;
    logic [WSEL_W-1:0]  r_wr_word, n_wr_word;
    logic               r_out_vld, n_out_vld;
    t_result            r_out, n_out;

    logic               in_fire;
    logic               is_newline;
    logic [PTR_W-1:0]   rd_total;
    logic               rd_more;
    logic               cmp_done;
    logic               eq_acc;
    logic [WORD_W-1:0]  cmp_word_data;
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_addr;
    logic [WORD_W-1:0]  ram_wdata;
    logic [WORD_W-1:0]  ram_rdata;

    assign o_s_axis_tready = (r_state == ST_IDLE) && (!r_out_vld || i_m_axis_tready);
    assign in_fire    = i_s_axis_tvalid && o_s_axis_tready;
    assign is_newline = (i_s_axis_tdata == NEWLINE_CODE);

    assign rd_total  = {r_blocks, {WSEL_W{1'b0}}};
    assign rd_more   = (r_rd_ptr != rd_total);
    assign cmp_done  = !rd_more && !r_cmp_vld;

    assign cmp_word_data = r_asm[{r_cmp_word, {BSEL_W{1'b0}}} +: CHARS_PER_WORD];
    assign eq_acc = (ram_rdata == cmp_word_data) && ((r_cmp_word == '0) || r_eq);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire && !is_newline && (r_pos == LAST_POS)
                    && (r_blocks < BLK_LIMIT)) begin
                    n_state = ST_CMP;
                end
            end
            ST_CMP: begin
                if (cmp_done) begin
                    n_state = ST_WR;
                end
            end
            ST_WR: begin
                if (r_wr_word == LAST_WORD) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // memory port and datapath
    always_comb begin
        n_asm       = r_asm;
        n_pos       = r_pos;
        n_blocks    = r_blocks;
        n_match     = r_match;
        n_lines     = r_lines;
        n_best_line = r_best_line;
        n_best_cnt  = r_best_cnt;
        n_rd_ptr    = r_rd_ptr;
        n_cmp_vld   = 1'b0;
        n_cmp_word  = r_cmp_word;
        n_eq        = r_eq;
        n_wr_word   = r_wr_word;
        n_out_vld   = r_out_vld && !i_m_axis_tready;
        n_out       = r_out;
        ram_we      = 1'b0;
        ram_addr    = r_rd_ptr[ADDR_W-1:0];
        ram_wdata   = r_asm[{r_wr_word, {BSEL_W{1'b0}}} +: CHARS_PER_WORD];
        unique case (r_state)
            ST_IDLE: begin
                n_rd_ptr  = '0;
                n_wr_word = '0;
                if (in_fire) begin
                    if (is_newline) begin
                        if (r_lines != LINE_MAX) begin
                            n_lines = r_lines + LINE_W'(1);
                        end
                        if (r_match > r_best_cnt) begin
                            n_best_cnt  = r_match;
                            n_best_line = n_lines;
                        end
                        n_out.line_number  = n_lines;
                        n_out.line_matches = r_match;
                        n_out.best_line    = n_best_line;
                        n_out.best_matches = n_best_cnt;
                        n_out_vld = 1'b1;
                        n_pos     = '0;
                        n_blocks  = '0;
                        n_match   = '0;
                    end else begin
                        n_asm[r_pos] = i_s_axis_tdata;
                        n_pos = r_pos + POS_W'(1);
                    end
                end
            end
            ST_CMP: begin
                // issue one read per cycle, compare the word read last cycle
                if (rd_more) begin
                    n_rd_ptr   = r_rd_ptr + PTR_W'(1);
                    n_cmp_vld  = 1'b1;
                    n_cmp_word = r_rd_ptr[WSEL_W-1:0];
                end
                if (r_cmp_vld) begin
                    n_eq = eq_acc;
                    if ((r_cmp_word == LAST_WORD) && eq_acc && (r_match != COUNT_MAX)) begin
                        n_match = r_match + COUNT_W'(1);
                    end
                end
            end
            ST_WR: begin
                ram_we    = 1'b1;
                ram_addr  = {r_blocks[IDX_W-1:0], r_wr_word};
                n_wr_word = r_wr_word + WSEL_W'(1);
                if (r_wr_word == LAST_WORD) begin
                    n_blocks = r_blocks + BLK_W'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pos       <= '0;
            r_blocks    <= '0;
            r_match     <= '0;
            r_lines     <= '0;
            r_best_line <= '0;
            r_best_cnt  <= '0;
            r_rd_ptr    <= '0;
            r_cmp_vld   <= 1'b0;
            r_wr_word   <= '0;
            r_out_vld   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_blocks    <= n_blocks;
            r_match     <= n_match;
            r_lines     <= n_lines;
            r_best_line <= n_best_line;
            r_best_cnt  <= n_best_cnt;
            r_rd_ptr    <= n_rd_ptr;
            r_cmp_vld   <= n_cmp_vld;
            r_wr_word   <= n_wr_word;
            r_out_vld   <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_asm      <= n_asm;
        r_cmp_word <= n_cmp_word;
        r_eq       <= n_eq;
        r_out      <= n_out;
    end

    ecbdd_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MEM_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {{(OUT_W - $bits(t_result)){1'b0}}, r_out};

endmodule

// ===== rtl/ecbdd_ram.sv =====
// ----------------------------------------------------------------------------
// ecbdd_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module ecbdd_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/ecbdd_checker.sv =====
// ----------------------------------------------------------------------------
// ecbdd_checker
// Port-level assertions for the repeated-block detector, bound to the top.
// ----------------------------------------------------------------------------
module ecbdd_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    input  logic                          o_s_axis_tready,
    input  logic [ecbdd_pkg::CHAR_W-1:0]  i_s_axis_tdata,
    input  logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    input  logic [ecbdd_pkg::OUT_W-1:0]   o_m_axis_tdata
);

    import ecbdd_pkg::*;

    logic in_fire;
    logic nl_fire;
    assign in_fire = i_s_axis_tvalid && o_s_axis_tready;
    assign nl_fire = in_fire && (i_s_axis_tdata == NEWLINE_CODE);

    // hold a stalled result transaction
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> (o_m_axis_tvalid && $stable(o_m_axis_tdata)))
        else $error("result changed while stalled");

    // a new result only follows a newline transaction
    a_out_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(nl_fire))
        else $error("result without newline");

    // best count covers the current line, best line is not in the future
    a_best_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> ((o_m_axis_tdata[53:43] >= o_m_axis_tdata[26:16])
                            && (o_m_axis_tdata[42:27] <= o_m_axis_tdata[15:0])))
        else $error("best line inconsistent");

    // no best line while no line has matched
    a_best_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tdata[53:43] == '0)) |-> (o_m_axis_tdata[42:27] == '0))
        else $error("best line set without matches");

    // accept no input while a result is stalled
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |-> !in_fire)
        else $error("input taken over stalled result");

endmodule

bind ecb_duplicate_block_detector_top ecbdd_checker u_ecbdd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Streams text lines into the repeated-block detector and checks every
// per-line result against a cycle-free prediction of pair counts, line
// numbers and the best line, under random idling and back-pressure.
// ----------------------------------------------------------------------------
module tb_top;
    import ecbdd_pkg::*;

    localparam int BLK_BITS     = BLOCK_CHARS * CHAR_W;
    localparam int IDLE_PCT     = 27;
    localparam int STALL_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 400;

    logic               i_clk;
    logic               i_rst_n         = 1'b0;
    logic               i_s_axis_tvalid = 1'b0;
    logic               o_s_axis_tready;
    logic [CHAR_W-1:0]  i_s_axis_tdata  = '0;
    logic               o_m_axis_tvalid;
    logic               i_m_axis_tready = 1'b0;
    logic [OUT_W-1:0]   o_m_axis_tdata;

    // line predictor state
    logic [BLK_BITS-1:0] cur_blk = '0;
    logic [BLK_BITS-1:0] line_blocks [MAX_BLOCKS];
    int                  char_pos   = 0;
    int                  n_blocks   = 0;
    int                  pair_count = 0;
    int                  lines_cnt  = 0;
    int                  best_ln    = 0;
    int                  best_cnt   = 0;
    t_result             pending_lines [$];

    int  n_err     = 0;
    int  n_sent    = 0;
    int  hold_left = 0;
    int  stuck     = 0;
    bit  idle_on   = 1'b1;

    ecb_duplicate_block_detector_top u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),   // [7:0] char_code
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        // [15:0] line_number, [26:16] line_matches, [42:27] best_line,
        // [53:43] best_matches, [55:54] zero
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // receiver: random idling, plus a long hold-off counted here
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_m_axis_tready <= 1'b0;
                hold_left--;
            end else begin
                i_m_axis_tready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            stuck = 0;
        else
            stuck++;
        if (stuck >= STALL_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_err++;
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_result got;
        t_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = t_result'(o_m_axis_tdata[$bits(t_result)-1:0]);
            if (pending_lines.size() == 0) begin
                $error("line result with none expected");
                n_err++;
            end else begin
                want = pending_lines.pop_front();
                check_field("line_number", 32'(want.line_number), 32'(got.line_number));
                check_field("line_matches", 32'(want.line_matches), 32'(got.line_matches));
                check_field("best_line", 32'(want.best_line), 32'(got.best_line));
                check_field("best_matches", 32'(want.best_matches), 32'(got.best_matches));
                check_field("pad", 32'd0, 32'(o_m_axis_tdata[OUT_W-1:$bits(t_result)]));
            end
        end
    end

    // advance the predicted line state by one character
    task automatic track_char(input logic [CHAR_W-1:0] c);
        t_result r;
        int      eq;
        int      i;
        if (c == NEWLINE_CODE) begin
            if (lines_cnt < int'(LINE_MAX))
                lines_cnt++;
            if (pair_count > best_cnt) begin
                best_cnt = pair_count;
                best_ln  = lines_cnt;
            end
            r.line_number  = LINE_W'(lines_cnt);
            r.line_matches = COUNT_W'(pair_count);
            r.best_line    = LINE_W'(best_ln);
            r.best_matches = COUNT_W'(best_cnt);
            pending_lines.push_back(r);
            char_pos   = 0;
            n_blocks   = 0;
            pair_count = 0;
        end else begin
            cur_blk[char_pos*CHAR_W +: CHAR_W] = c;
            if (char_pos == BLOCK_CHARS - 1) begin
                char_pos = 0;
                // drop blocks past capacity
                if (n_blocks < MAX_BLOCKS) begin
                    eq = 0;
                    for (i = 0; i < n_blocks; i++)
                        if (line_blocks[i] == cur_blk)
                            eq++;
                    pair_count = (pair_count + eq > int'(COUNT_MAX)) ?
                                 int'(COUNT_MAX) : pair_count + eq;
                    line_blocks[n_blocks] = cur_blk;
                    n_blocks++;
                end
            end else begin
                char_pos++;
            end
        end
    endtask

    task automatic send_char(input logic [CHAR_W-1:0] c);
        @(negedge i_clk);
        while (idle_on && $urandom_range(99) < IDLE_PCT) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= c;
        do @(posedge i_clk); while (!o_s_axis_tready);
        n_sent++;
        track_char(c);
    endtask

    task automatic send_block(input logic [BLK_BITS-1:0] b, input int n);
        int k;
        for (k = 0; k < n; k++)
            send_char(b[k*CHAR_W +: CHAR_W]);
    endtask

    // hold the sender until every line result is in, then let the block settle
    task automatic drain_results();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (pending_lines.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [CHAR_W-1:0] rand_char();
        logic [CHAR_W-1:0] c;
        do c = CHAR_W'($urandom_range(255)); while (c == NEWLINE_CODE);
        return c;
    endfunction

    function automatic logic [BLK_BITS-1:0] rand_block();
        logic [BLK_BITS-1:0] b;
        int                  k;
        for (k = 0; k < BLOCK_CHARS; k++)
            b[k*CHAR_W +: CHAR_W] = rand_char();
        return b;
    endfunction

    task automatic test_corner_lines();
        logic [BLK_BITS-1:0] alt;
        logic [BLK_BITS-1:0] one_off;
        int                  k;
        for (k = 0; k < BLOCK_CHARS; k++)
            alt[k*CHAR_W +: CHAR_W] = (k % 2) ? 8'hFF : 8'h00;
        one_off = alt;
        one_off[BLK_BITS-1 -: CHAR_W] = 8'h0D;   // carriage return is plain data
        send_char(NEWLINE_CODE);
        send_block(alt, BLOCK_CHARS - 1);
        send_char(NEWLINE_CODE);
        // three equal blocks, trailing copy left partial
        repeat (3) send_block(alt, BLOCK_CHARS);
        send_block(alt, BLOCK_CHARS - 1);
        send_char(NEWLINE_CODE);
        // blocks stored by earlier lines must not count
        send_block(alt, BLOCK_CHARS);
        send_char(NEWLINE_CODE);
        send_block(alt, BLOCK_CHARS);
        send_block(one_off, BLOCK_CHARS);
        send_block(one_off, BLOCK_CHARS);
        send_char(NEWLINE_CODE);
        // equal count to the best: first line keeps it
        repeat (3) send_block(alt, BLOCK_CHARS);
        send_char(NEWLINE_CODE);
        drain_results();
    endtask

    task automatic test_random_lines();
        logic [BLK_BITS-1:0] pal [3];
        int                  n_pal;
        int                  k;
        int                  start_chars;
        int                  start_lines;
        int                  line_idx;
        start_chars = n_sent;
        start_lines = lines_cnt;
        line_idx    = 0;
        while (n_sent - start_chars < 400 || lines_cnt - start_lines < 14) begin
            idle_on = !(line_idx >= 4 && line_idx < 10);
            if ($urandom_range(99) < 20) begin
                repeat ($urandom_range(40)) send_char(CHAR_W'($urandom_range(255)));
            end else begin
                n_pal = $urandom_range(3, 1);
                for (k = 0; k < n_pal; k++)
                    pal[k] = rand_block();
                repeat ($urandom_range(4))
                    send_block(pal[$urandom_range(n_pal - 1)], BLOCK_CHARS);
                send_block(pal[$urandom_range(n_pal - 1)], $urandom_range(BLOCK_CHARS - 1));
            end
            send_char(NEWLINE_CODE);
            line_idx++;
        end
        idle_on = 1'b1;
        drain_results();
    endtask

    task automatic test_backpressure();
        logic [BLK_BITS-1:0] b;
        b = rand_block();
        hold_left = HOLD_CYCLES;
        send_block(b, BLOCK_CHARS);
        send_block(b, BLOCK_CHARS);
        send_char(NEWLINE_CODE);
        repeat (40) begin
            send_char(rand_char());
            send_char(NEWLINE_CODE);
        end
        drain_results();
    endtask

    task automatic test_capacity();
        logic [BLK_BITS-1:0] b;
        // copies beyond capacity must be neither compared nor stored
        b = rand_block();
        repeat (MAX_BLOCKS + 2) send_block(b, BLOCK_CHARS);
        send_char(NEWLINE_CODE);
        drain_results();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_corner_lines();
        test_random_lines();
        test_backpressure();
        test_capacity();
        if (n_err == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
